// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl of the trace meter
// depends on nothing; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define TMRPM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define TMRPM_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("forbidden condition");
`else
`define TMRPM_ASSERT(lbl, clk, rst_n, prop)
`define TMRPM_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== src/tmrpm_pkg.sv =====
// types and constants of the trace mean / rms / peak meter
// depends on nothing
`timescale 1ns / 1ps
package tmrpm_pkg;
    localparam int VALUE_BITS = 16;
    localparam int SPAN_BITS  = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int VINT_BITS  = 42;
    localparam int SINT_BITS  = 57;
    localparam int DIV_N      = SINT_BITS;
    localparam int DIV_D      = SPAN_BITS + 1;
    localparam int SQRT_BITS  = 32;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FEW      = 2'd1;
    localparam logic [1:0] STAT_TIME     = 2'd2;
    localparam logic [1:0] STAT_SPAN_OVF = 2'd3;

    typedef struct packed {
        logic [31:0]                    sample_time;
        logic signed [VALUE_BITS-1:0]   sample_value;
        logic                           last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] mean_value;
        logic [15:0]        rms_value;
        logic [15:0]        ac_rms_value;
        logic signed [15:0] min_value;
        logic signed [15:0] max_value;
        logic [15:0]        peak_to_peak;
        logic [1:0]         status;
    } t_out_item;
endpackage

// ===== src/trace_mean_rms_peak_meter_top.sv =====
// top level of the trace mean / rms / peak meter
// depends on tmrpm_pkg, tmrpm_front, tmrpm_back
//
//   channel   direction  handshake        payload
//   samples   in         push / full      i_item  (t_in_item)
//   results   out        empty / pop      o_result (t_out_item)
//
// a sample passes idle, check and update when accumulation is skipped, and runs
// the six multiply and add steps of the accumulator between check and update otherwise;
// a last sample of a valid trace adds the two serial divisions and square roots
// a four entry queue takes samples while the back end works; results wait in one
// output register and the back end holds while it is occupied
// reset is synchronous, active low, and clears the trace state, the queue and the output register
`timescale 1ns / 1ps
module trace_mean_rms_peak_meter_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  tmrpm_pkg::t_in_item  i_item,
    output logic                 empty,
    input  logic                 pop,
    output tmrpm_pkg::t_out_item o_result
);
    import tmrpm_pkg::*;

    logic     w_q_empty;
    logic     w_q_pop;
    t_in_item w_q_item;

    tmrpm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    tmrpm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );
endmodule

// ===== src/tmrpm_front.sv =====
// front queue: accepts samples and holds them for the accumulator
// depends on tmrpm_pkg
`timescale 1ns / 1ps
module tmrpm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tmrpm_pkg::t_in_item i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output tmrpm_pkg::t_in_item o_item
);
    import tmrpm_pkg::*;

    t_in_item             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_AW:0]     r_cnt;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (w_rd && !w_wr) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

// ===== src/tmrpm_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on tmrpm_pkg
`timescale 1ns / 1ps
module tmrpm_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tmrpm_pkg::DIV_N-1:0]    i_dividend,
    input  logic [tmrpm_pkg::DIV_D-1:0]    i_divisor,
    output logic                           o_done,
    output logic [tmrpm_pkg::DIV_N-1:0]    o_quotient,
    output logic                           o_rem_nz
);
    import tmrpm_pkg::*;
    localparam int CW = $clog2(DIV_N + 1);

    logic [DIV_N-1:0] r_quo;
    logic [DIV_D-1:0] r_rem;
    logic [DIV_D-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [DIV_D:0]   w_trial;
    logic             w_ge;

    assign w_trial    = {r_rem, r_quo[DIV_N-1]};
    assign w_ge       = (w_trial >= {1'b0, r_den});
    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_rem_nz   = |r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_N-2:0], w_ge};
            r_rem <= w_ge ? DIV_D'(w_trial - {1'b0, r_den}) : w_trial[DIV_D-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start) r_cnt <= CW'(DIV_N);
            else if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

// ===== src/tmrpm_isqrt.sv =====
// bitwise integer square root, one result bit per cycle
// depends on tmrpm_pkg
`timescale 1ns / 1ps
module tmrpm_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [tmrpm_pkg::SQRT_BITS-1:0] i_x,
    output logic                            o_done,
    output logic [15:0]                     o_root
);
    import tmrpm_pkg::*;
    localparam int STEPS = SQRT_BITS / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [SQRT_BITS-1:0] r_x;
    logic [SQRT_BITS-1:0] r_r;
    logic [SQRT_BITS-1:0] r_bit;
    logic [CW-1:0]        r_cnt;
    logic                 r_done;
    logic [SQRT_BITS:0]   w_sum;
    logic                 w_ge;

    assign w_sum  = {1'b0, r_r} + {1'b0, r_bit};
    assign w_ge   = ({1'b0, r_x} >= w_sum);
    assign o_done = r_done;
    assign o_root = r_r[15:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_r   <= '0;
            r_bit <= SQRT_BITS'(1) << (SQRT_BITS - 2);
        end else if (r_cnt != '0) begin
            if (w_ge) begin
                r_x <= SQRT_BITS'({1'b0, r_x} - w_sum);
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CW'(1));
            if (i_start) r_cnt <= CW'(STEPS);
            else if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

// ===== src/tmrpm_back.sv =====
// back end: trapezoidal accumulation, final statistics and result register
// depends on tmrpm_pkg, tmrpm_div, tmrpm_isqrt, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tmrpm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  tmrpm_pkg::t_in_item  i_q_item,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output tmrpm_pkg::t_out_item o_result
);
    import tmrpm_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CHK  = 5'd1;
    localparam logic [4:0] S_M0   = 5'd2;
    localparam logic [4:0] S_M1   = 5'd3;
    localparam logic [4:0] S_M2   = 5'd4;
    localparam logic [4:0] S_M3   = 5'd5;
    localparam logic [4:0] S_M4   = 5'd6;
    localparam logic [4:0] S_M5   = 5'd7;
    localparam logic [4:0] S_UPD  = 5'd8;
    localparam logic [4:0] S_DS1  = 5'd9;
    localparam logic [4:0] S_DW1  = 5'd10;
    localparam logic [4:0] S_DS2  = 5'd11;
    localparam logic [4:0] S_DW2  = 5'd12;
    localparam logic [4:0] S_MSQ  = 5'd13;
    localparam logic [4:0] S_QS1  = 5'd14;
    localparam logic [4:0] S_QW1  = 5'd15;
    localparam logic [4:0] S_QS2  = 5'd16;
    localparam logic [4:0] S_QW2  = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    logic [4:0]                   r_state;
    t_in_item                     r_item;
    logic [1:0]                   r_count;
    logic [31:0]                  r_prev_time;
    logic signed [VALUE_BITS-1:0] r_prev_val;
    logic signed [VINT_BITS-1:0]  r_vint;
    logic [SINT_BITS-1:0]         r_sint;
    logic [SPAN_BITS-1:0]         r_span;
    logic signed [VALUE_BITS-1:0] r_min;
    logic signed [VALUE_BITS-1:0] r_max;
    logic [1:0]                   r_err;
    logic [SPAN_BITS-1:0]         r_dt;
    logic signed [VALUE_BITS:0]   r_sv;
    logic signed [VINT_BITS-1:0]  r_vprod;
    logic [31:0]                  r_pp;
    logic [32:0]                  r_sq;
    logic [40:0]                  r_lo;
    logic [39:0]                  r_hi;
    logic signed [15:0]           r_mean;
    logic [31:0]                  r_ms;
    logic [31:0]                  r_ac;
    t_out_item                    r_res;
    t_out_item                    r_out;
    logic                         r_out_valid;

    logic [31:0]                  w_dt32;
    logic [32:0]                  w_ns;
    logic                         w_ovf;
    logic signed [31:0]           w_pp;
    logic signed [31:0]           w_yy;
    logic signed [31:0]           w_m2;
    logic                         w_neg;
    logic [VINT_BITS-1:0]         w_mag;
    logic [16:0]                  w_q17;
    logic [16:0]                  w_m17;
    logic signed [VALUE_BITS:0]   w_p2p;
    logic                         w_div_start;
    logic [DIV_N-1:0]             w_div_num;
    logic                         w_div_done;
    logic [DIV_N-1:0]             w_div_q;
    logic                         w_div_rnz;
    logic                         w_sq_start;
    logic [SQRT_BITS-1:0]         w_sq_x;
    logic                         w_sq_done;
    logic [15:0]                  w_sq_root;

    assign w_dt32 = r_item.sample_time - r_prev_time;
    assign w_ns   = {{(33-SPAN_BITS){1'b0}}, r_span} + {1'b0, w_dt32};
    assign w_ovf  = |w_ns[32:SPAN_BITS];
    assign w_pp   = r_prev_val * r_prev_val;
    assign w_yy   = r_item.sample_value * r_item.sample_value;
    assign w_m2   = r_mean * r_mean;
    assign w_neg  = r_vint[VINT_BITS-1];
    assign w_mag  = w_neg ? VINT_BITS'(-r_vint) : VINT_BITS'(r_vint);
    assign w_q17  = w_div_q[16:0];
    assign w_m17  = w_neg ? (17'(-w_q17) - 17'(w_div_rnz)) : w_q17;
    assign w_p2p  = {r_max[VALUE_BITS-1], r_max} - {r_min[VALUE_BITS-1], r_min};

    assign w_div_start = (r_state == S_DS1) || (r_state == S_DS2);
    assign w_div_num   = (r_state == S_DS1) ? {{(DIV_N-VINT_BITS){1'b0}}, w_mag} : r_sint;
    assign w_sq_start  = (r_state == S_QS1) || (r_state == S_QS2);
    assign w_sq_x      = (r_state == S_QS1) ? r_ms : r_ac;

    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    tmrpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  ({r_span, 1'b0}),
        .o_done     (w_div_done),
        .o_quotient (w_div_q),
        .o_rem_nz   (w_div_rnz)
    );

    tmrpm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_x     (w_sq_x),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (!i_q_empty) r_item <= i_q_item;
            S_CHK: begin
                r_dt <= w_dt32[SPAN_BITS-1:0];
                r_sv <= {r_prev_val[VALUE_BITS-1], r_prev_val}
                      + {r_item.sample_value[VALUE_BITS-1], r_item.sample_value};
            end
            S_M0:  r_vprod <= r_sv * $signed({1'b0, r_dt});
            S_M1:  r_pp <= $unsigned(w_pp);
            S_M2:  r_sq <= {1'b0, r_pp} + {1'b0, $unsigned(w_yy)};
            S_M3:  r_lo <= r_sq[16:0] * r_dt;
            S_M4:  r_hi <= r_sq[32:17] * r_dt;
            S_UPD: begin
                r_res <= '{status: ((r_count != 2'd2) ? STAT_FEW : r_err), default: '0};
            end
            S_DW1: if (w_div_done) r_mean <= w_m17[15:0];
            S_DW2: if (w_div_done) r_ms <= w_div_q[31:0];
            S_MSQ: begin
                r_ac  <= (r_ms > $unsigned(w_m2)) ? (r_ms - $unsigned(w_m2)) : '0;
                r_res <= '{mean_value: r_mean, min_value: r_min, max_value: r_max,
                           peak_to_peak: w_p2p[15:0], status: STAT_OK, default: '0};
            end
            S_QW1: if (w_sq_done) r_res.rms_value <= w_sq_root;
            S_QW2: if (w_sq_done) r_res.ac_rms_value <= w_sq_root;
            S_OUT: if (!r_out_valid) r_out <= r_res;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_prev_time <= '0;
            r_prev_val  <= '0;
            r_vint      <= '0;
            r_sint      <= '0;
            r_span      <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_err       <= STAT_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (!i_q_empty) r_state <= S_CHK;
                S_CHK: begin
                    r_state <= S_UPD;
                    if (r_count == 2'd0) begin
                        r_min   <= r_item.sample_value;
                        r_max   <= r_item.sample_value;
                        r_count <= 2'd1;
                    end else begin
                        if (r_item.sample_value < r_min) r_min <= r_item.sample_value;
                        if (r_item.sample_value > r_max) r_max <= r_item.sample_value;
                        r_count <= 2'd2;
                        if (r_err == STAT_OK) begin
                            if (r_item.sample_time <= r_prev_time) r_err <= STAT_TIME;
                            else if (w_ovf) r_err <= STAT_SPAN_OVF;
                            else r_state <= S_M0;
                        end
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: r_state <= S_M4;
                S_M4: r_state <= S_M5;
                S_M5: begin
                    r_vint  <= r_vint + r_vprod;
                    r_sint  <= r_sint + SINT_BITS'({r_hi, 17'b0}) + SINT_BITS'(r_lo);
                    r_span  <= r_span + r_dt;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_prev_time <= r_item.sample_time;
                    r_prev_val  <= r_item.sample_value;
                    if (!r_item.last_sample) r_state <= S_IDLE;
                    else if (r_count != 2'd2 || r_err != STAT_OK) r_state <= S_OUT;
                    else r_state <= S_DS1;
                end
                S_DS1: r_state <= S_DW1;
                S_DW1: if (w_div_done) r_state <= S_DS2;
                S_DS2: r_state <= S_DW2;
                S_DW2: if (w_div_done) r_state <= S_MSQ;
                S_MSQ: r_state <= S_QS1;
                S_QS1: r_state <= S_QW1;
                S_QW1: if (w_sq_done) r_state <= S_QS2;
                S_QS2: r_state <= S_QW2;
                S_QW2: if (w_sq_done) r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_count     <= '0;
                        r_prev_time <= '0;
                        r_prev_val  <= '0;
                        r_vint      <= '0;
                        r_sint      <= '0;
                        r_span      <= '0;
                        r_min       <= '0;
                        r_max       <= '0;
                        r_err       <= STAT_OK;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TMRPM_ASSERT(a_div_done_waits, i_clk, i_rst_n, w_div_done |-> (r_state == S_DW1 || r_state == S_DW2))
    `TMRPM_ASSERT(a_sq_done_waits, i_clk, i_rst_n, w_sq_done |-> (r_state == S_QW1 || r_state == S_QW2))
    `TMRPM_ASSERT(a_err_needs_two, i_clk, i_rst_n, (r_err != STAT_OK) |-> (r_count == 2'd2))
    `TMRPM_ASSERT(a_clear_trace, i_clk, i_rst_n, (r_count == 2'd0) |-> (r_span == '0 && r_err == STAT_OK))
    `TMRPM_NEVER(a_no_pop_busy, i_clk, i_rst_n, o_q_pop && r_state != S_IDLE)
endmodule

// ===== tb/tb_trace_mean_rms_peak_meter_top.sv =====
// testbench of the trace mean / rms / peak meter: drives timestamped samples, predicts each
// trace result and compares it with what the block delivers
// depends on tmrpm_pkg and trace_mean_rms_peak_meter_top
`timescale 1ns / 1ps
module tb_trace_mean_rms_peak_meter_top;
    import tmrpm_pkg::*;

    class trace_scoreboard;
        int unsigned n_seen;
        int unsigned n_fail;
        t_out_item   pending_results[$];
        logic [1:0]  cnt;
        logic [31:0] prev_t;
        longint      prev_v;
        longint      vsum;
        longint unsigned sqsum;
        longint unsigned span;
        longint      vmin;
        longint      vmax;
        logic [1:0]  err;

        function new();
            n_seen = 0;
            n_fail = 0;
            clear_trace();
        endfunction

        function void clear_trace();
            cnt = 0;
            prev_t = 0;
            prev_v = 0;
            vsum = 0;
            sqsum = 0;
            span = 0;
            vmin = 0;
            vmax = 0;
            err = STAT_OK;
        endfunction

        function longint unsigned root_floor(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_sample(t_in_item it);
            longint y;
            longint unsigned dt;
            longint unsigned ns;
            longint d;
            longint m;
            longint unsigned ms;
            longint unsigned m2;
            longint unsigned ac;
            t_out_item r;
            y = longint'(it.sample_value);
            if (cnt == 0) begin
                vmin = y;
                vmax = y;
                cnt = 1;
            end else begin
                if (err == STAT_OK) begin
                    if (it.sample_time <= prev_t) begin
                        err = STAT_TIME;
                    end else begin
                        dt = longint'(it.sample_time - prev_t);
                        ns = span + dt;
                        if (ns >= (64'd1 << SPAN_BITS)) begin
                            err = STAT_SPAN_OVF;
                        end else begin
                            vsum = vsum + (prev_v + y) * longint'(dt);
                            sqsum = sqsum + (prev_v * prev_v + y * y) * dt;
                            span = ns;
                        end
                    end
                end
                if (y < vmin) vmin = y;
                if (y > vmax) vmax = y;
                cnt = 2;
            end
            prev_t = it.sample_time;
            prev_v = y;
            if (!it.last_sample) return;
            r = '0;
            if (cnt < 2) begin
                r.status = STAT_FEW;
            end else if (err != STAT_OK) begin
                r.status = err;
            end else begin
                d = longint'(span * 2);
                m = vsum / d;
                if ((vsum % d) != 0 && vsum < 0) m = m - 1;
                ms = sqsum / d;
                m2 = m * m;
                ac = (ms > m2) ? ms - m2 : 0;
                r.mean_value = m[15:0];
                r.rms_value = 16'(root_floor(ms));
                r.ac_rms_value = 16'(root_floor(ac));
                r.min_value = vmin[15:0];
                r.max_value = vmax[15:0];
                r.peak_to_peak = 16'(vmax - vmin);
                r.status = STAT_OK;
            end
            pending_results.insert(pending_results.size(), r);
            clear_trace();
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            n_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_fail++;
                return;
            end
            e = pending_results.pop_front();
            if (got.mean_value !== e.mean_value) begin
                $display("%0t: mean exp %0d got %0d", $time, e.mean_value, got.mean_value);
                n_fail++;
            end
            if (got.rms_value !== e.rms_value) begin
                $display("%0t: rms exp %0d got %0d", $time, e.rms_value, got.rms_value);
                n_fail++;
            end
            if (got.ac_rms_value !== e.ac_rms_value) begin
                $display("%0t: ac rms exp %0d got %0d", $time, e.ac_rms_value,
                         got.ac_rms_value);
                n_fail++;
            end
            if (got.min_value !== e.min_value) begin
                $display("%0t: min exp %0d got %0d", $time, e.min_value, got.min_value);
                n_fail++;
            end
            if (got.max_value !== e.max_value) begin
                $display("%0t: max exp %0d got %0d", $time, e.max_value, got.max_value);
                n_fail++;
            end
            if (got.peak_to_peak !== e.peak_to_peak) begin
                $display("%0t: p2p exp %0d got %0d", $time, e.peak_to_peak,
                         got.peak_to_peak);
                n_fail++;
            end
            if (got.status !== e.status) begin
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                n_fail++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_result;

    trace_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  idle_cycles;
    logic [31:0] now_t;

    trace_mean_rms_peak_meter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && !empty && pop) sb.check_result(o_result);
    end

    // result side: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (recv_hold) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= 20000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic hold_receiver();
        @(negedge i_clk);
        recv_hold = 1'b1;
        repeat (600) @(negedge i_clk);
        recv_hold = 1'b0;
    endtask

    task automatic send(input logic [31:0] t, input logic [15:0] v, input bit last);
        t_in_item it;
        it.sample_time = t;
        it.sample_value = v;
        it.last_sample = last;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_sample(it);
    endtask

    // one trace with random content and timing, often broken by bad timestamps or a span overflow
    task automatic random_trace();
        int n;
        int kind;
        logic [31:0] dt;
        n = $urandom_range(1, 8);
        kind = $urandom_range(99);
        for (int k = 0; k < n; k++) begin
            if (kind < 5 && k == n - 1) dt = 0;
            else if (kind < 8) dt = $urandom;
            else if (kind < 12) dt = $urandom_range(0, 3) << 21;
            else if (kind < 20) dt = $urandom_range(1, 4000);
            else dt = $urandom_range(1, 40);
            if (kind < 3 && k > 0) now_t = now_t - $urandom_range(0, 50);
            else now_t = now_t + dt;
            if ($urandom_range(3) == 0) send($urandom, 16'($urandom), k == n - 1);
            else send(now_t, (kind % 3 == 0) ? 16'($urandom_range(0, 1) ? 16'h8000
                 : 16'h7fff) : 16'($urandom), k == n - 1);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        push <= 1'b0;
        i_item <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        now_t = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(32'd5, 16'h1234, 1'b1);
        send(32'd0, 16'h8000, 1'b0);
        send(32'd1, 16'h7fff, 1'b1);
        send(32'd10, 16'h7fff, 1'b0);
        send(32'd20, 16'h7fff, 1'b1);
        send(32'hffff_fff0, 16'h8000, 1'b0);
        send(32'hffff_fff8, 16'h8000, 1'b0);
        send(32'hffff_ffff, 16'h0001, 1'b1);
        send(32'd100, 16'h0005, 1'b0);
        send(32'd100, 16'h0006, 1'b0);
        send(32'd200, 16'hfff0, 1'b1);
        send(32'd0, 16'h0003, 1'b0);
        send(32'h00ff_ffff, 16'h0004, 1'b1);
        send(32'd0, 16'hfffd, 1'b0);
        send(32'h0100_0000, 16'h0002, 1'b0);
        send(32'd5, 16'h0002, 1'b1);
        send(32'd7, 16'hffff, 1'b0);
        send(32'd9, 16'h0000, 1'b0);
        send(32'd12, 16'h0001, 1'b1);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 9 : 48) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 9 : 48) : 0;
            if (phase == 2) begin
                fork
                    hold_receiver();
                join_none
            end
            for (int i = 0; i < 50; i++) random_trace();
            if (phase == 1) drain();
        end
        drain();
        if (sb.n_fail == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/tmrpm_pkg.sv
src/tmrpm_front.sv
src/tmrpm_div.sv
src/tmrpm_isqrt.sv
src/tmrpm_back.sv
src/trace_mean_rms_peak_meter_top.sv
tb/tb_trace_mean_rms_peak_meter_top.sv
